// ===== rtl/knap_pkg.sv =====
package knap_pkg;

    localparam int MAX_ITEMS    = 16;
    localparam int MAX_CAPACITY = 255;
    localparam int VALUE_BITS   = 16;

    localparam int WEIGHT_W = 8;
    localparam int IN_VAL_W = 16;
    localparam int CFG_W    = 8;
    localparam int DATA_W   = 20;

    localparam int ROW_LEN = MAX_CAPACITY + 1;
    localparam int CAP_W   = $clog2(ROW_LEN);
    localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int COUNT_W = $clog2(MAX_ITEMS + 1);
    localparam int TAKE_AW = IDX_W + CAP_W;

    localparam logic [IN_VAL_W-1:0] VAL_MASK =
        (VALUE_BITS >= IN_VAL_W) ? {IN_VAL_W{1'b1}}
                                 : IN_VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

    localparam logic RES_TOTAL = 1'b0;
    localparam logic RES_ITEM  = 1'b1;

    typedef struct packed {
        logic [WEIGHT_W-1:0] item_weight;
        logic [IN_VAL_W-1:0] item_value;
        logic                last_item;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [DATA_W-1:0] result_data;
        logic              last_result;
    } t_out_item;

    // best-value row: two reads, one write, whole-row clear
    typedef struct packed {
        logic [CAP_W-1:0]  raddr_a;
        logic [CAP_W-1:0]  raddr_b;
        logic              we;
        logic [CAP_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              clr;
    } t_row_req;

    typedef struct packed {
        logic               we;
        logic [TAKE_AW-1:0] waddr;
        logic               wdata;
        logic [TAKE_AW-1:0] raddr;
    } t_take_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FLUSH,
        ST_BT_REQ,
        ST_BT_CHK,
        ST_TOTAL,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/knapsack_01_dp_engine.sv =====
// Channel   Dir  Signals                                  Transfer when
// -------   ---  ---------------------------------------  -------------------------
// in        in   i_in_valid, o_in_stall, i_in_data         i_in_valid & !o_in_stall
// out       out  o_out_valid, i_out_stall, o_out_data      o_out_valid & !i_out_stall
// cfg       in   i_cfg_we, i_cfg_wdata (capacity)          i_cfg_we
//
// Each loaded item is accepted, then walks down from the latched capacity with one
// row-RAM read per capacity entry, then drains. After the last item, backtracking
// visits each loaded item in turn (take-bit RAM read, then decide), then the total
// is emitted, then the item numbers are scanned from 1 up to the highest included
// item, and any output stall holds the engine in those steps.
// Reset (synchronous, active low) clears control and the row valid bits; the
// take-bit RAM needs no clearing. Output stalls hold the result register and,
// while it is full, the engine in its output states; input stays stalled meanwhile.
module knapsack_01_dp_engine
    import knap_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    logic [CFG_W-1:0] r_capacity;
    logic             r_out_vld;
    t_out_item        r_out;

    logic             slot_free;
    logic             push;
    t_out_item        res;
    t_row_req         row_req;
    logic [DATA_W-1:0] row_a;
    logic [DATA_W-1:0] row_b;
    t_take_req        take_req;
    logic             take_bit;

    // capacity register; sampled by the engine on the first item of a set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // result register: engine may load it whenever it is empty or draining
    assign slot_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= res;
        end
    end

    knap_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_capacity  (r_capacity),
        .i_slot_free (slot_free),
        .o_push      (push),
        .o_res       (res),
        .o_row_req   (row_req),
        .i_row_a     (row_a),
        .i_row_b     (row_b),
        .o_take_req  (take_req),
        .i_take_bit  (take_bit)
    );

    // best value per capacity, two read ports for best[j] and best[j - weight]
    knap_row_mem u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (row_req),
        .o_rd_a  (row_a),
        .o_rd_b  (row_b)
    );

    // one take bit per (item, capacity)
    knap_take_mem u_take (
        .i_clk   (i_clk),
        .i_req   (take_req),
        .o_rdata (take_bit)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // row clear and row update never share a cycle
    a_clr_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_req.clr |-> !row_req.we)
        else $error("row clear collides with row write");

    // the engine never produces a result in a cycle an input transfer happens
    a_push_not_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !push)
        else $error("result pushed while accepting an item");

    // item numbers are 1-based and within the item limit
    a_item_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == RES_ITEM)) |->
        ((o_out_data.result_data != '0) &&
         (o_out_data.result_data <= DATA_W'(MAX_ITEMS))))
        else $error("item number out of range");

    // a result is only loaded while the result register is empty or draining
    a_push_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> slot_free)
        else $error("result pushed into a full register");

endmodule

// ===== rtl/knap_row_mem.sv =====
module knap_row_mem
    import knap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_row_req          i_req,
    output logic [DATA_W-1:0] o_rd_a,
    output logic [DATA_W-1:0] o_rd_b
);

    logic [DATA_W-1:0]  mem [ROW_LEN];
    logic [ROW_LEN-1:0] r_vld;
    logic [DATA_W-1:0]  r_a_data;
    logic [DATA_W-1:0]  r_b_data;
    logic               r_a_vld;
    logic               r_b_vld;

    // read-before-write on the same entry
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_a_data <= mem[i_req.raddr_a];
        r_b_data <= mem[i_req.raddr_b];
        r_a_vld  <= r_vld[i_req.raddr_a];
        r_b_vld  <= r_vld[i_req.raddr_b];
    end

    // entry not written since last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.we) begin
            r_vld[i_req.waddr] <= 1'b1;
        end
    end

    assign o_rd_a = r_a_vld ? r_a_data : '0;
    assign o_rd_b = r_b_vld ? r_b_data : '0;

endmodule

// ===== rtl/knap_take_mem.sv =====
module knap_take_mem
    import knap_pkg::*;
(
    input  logic      i_clk,
    input  t_take_req i_req,
    output logic      o_rdata
);

    logic mem [2**TAKE_AW];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/knap_seq.sv =====
module knap_seq
    import knap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_item          i_in_data,
    output logic              o_in_stall,
    input  logic [CFG_W-1:0]  i_capacity,
    input  logic              i_slot_free,
    output logic              o_push,
    output t_out_item         o_res,
    output t_row_req          o_row_req,
    input  logic [DATA_W-1:0] i_row_a,
    input  logic [DATA_W-1:0] i_row_b,
    output t_take_req         o_take_req,
    input  logic              i_take_bit
);

    t_state              r_state, n_state;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [CAP_W-1:0]    r_set_cap, n_set_cap;
    logic [WEIGHT_W-1:0] r_w, n_w;
    logic [DATA_W-1:0]   r_v, n_v;
    logic                r_last, n_last;
    logic [CAP_W-1:0]    r_j, n_j;
    logic                r_s2_vld, n_s2_vld;
    logic [CAP_W-1:0]    r_s2_j, n_s2_j;
    logic                r_s2_fit, n_s2_fit;
    logic [WEIGHT_W-1:0] r_wt [MAX_ITEMS];
    logic [COUNT_W-1:0]  r_bi, n_bi;
    logic [CAP_W-1:0]    r_bj, n_bj;
    logic [MAX_ITEMS-1:0] r_pick, n_pick;
    logic [IDX_W-1:0]    r_e, n_e;

    logic                accept;
    logic [CAP_W-1:0]    cap_sat;
    logic [CAP_W-1:0]    cap_use;
    logic                room;
    logic [DATA_W:0]     sum;
    logic [DATA_W-1:0]   cand;
    logic                take;
    logic [IDX_W-1:0]    bi_idx;
    logic [MAX_ITEMS-1:0] e_bit;
    logic [MAX_ITEMS-1:0] pick_rest;
    logic                wt_we;

    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign cap_sat = (32'(i_capacity) > 32'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY)
                                                           : CAP_W'(i_capacity);
    assign cap_use = (r_count == '0) ? cap_sat : r_set_cap;
    assign room    = (r_count < COUNT_W'(MAX_ITEMS));

    // stage 2: candidate with saturation, strict improvement only
    assign sum  = {1'b0, i_row_b} + (DATA_W + 1)'(r_v);
    assign cand = sum[DATA_W] ? {DATA_W{1'b1}} : sum[DATA_W-1:0];
    assign take = r_s2_vld && r_s2_fit && (cand > i_row_a);

    assign bi_idx    = IDX_W'(r_bi - COUNT_W'(1));
    assign e_bit     = MAX_ITEMS'(1) << r_e;
    assign pick_rest = r_pick & ~e_bit;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (room) begin
                        n_state = ST_FILL;
                    end else if (i_in_data.last_item) begin
                        n_state = ST_BT_REQ;
                    end
                end
            end
            ST_FILL: begin
                if (r_j == '0) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = r_last ? ST_BT_REQ : ST_IDLE;
            end
            ST_BT_REQ: begin
                n_state = (r_bi == '0) ? ST_TOTAL : ST_BT_CHK;
            end
            ST_BT_CHK: begin
                n_state = ST_BT_REQ;
            end
            ST_TOTAL: begin
                if (i_slot_free) begin
                    n_state = (r_pick == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (r_pick[r_e] && i_slot_free && (pick_rest == '0)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count   = r_count;
        n_set_cap = r_set_cap;
        n_w       = r_w;
        n_v       = r_v;
        n_last    = r_last;
        n_j       = r_j;
        n_bi      = r_bi;
        n_bj      = r_bj;
        n_pick    = r_pick;
        n_e       = r_e;
        n_s2_vld  = (r_state == ST_FILL);
        n_s2_j    = r_j;
        n_s2_fit  = (32'(r_w) <= 32'(r_j));
        wt_we     = 1'b0;

        o_push = 1'b0;
        o_res  = '{result_kind: RES_TOTAL, result_data: i_row_a, last_result: 1'b0};

        o_row_req.raddr_a = (r_state == ST_FILL) ? r_j : r_set_cap;
        o_row_req.raddr_b = r_j - CAP_W'(r_w);
        o_row_req.we      = take;
        o_row_req.waddr   = r_s2_j;
        o_row_req.wdata   = cand;
        o_row_req.clr     = 1'b0;

        o_take_req.we    = r_s2_vld;
        o_take_req.waddr = {IDX_W'(r_count), r_s2_j};
        o_take_req.wdata = take;
        o_take_req.raddr = {bi_idx, r_bj};

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_set_cap = cap_use;
                    if (room) begin
                        n_w    = i_in_data.item_weight;
                        n_v    = DATA_W'(i_in_data.item_value & VAL_MASK);
                        n_last = i_in_data.last_item;
                        n_j    = cap_use;
                        wt_we  = 1'b1;
                    end else begin
                        n_bi   = r_count;
                        n_bj   = r_set_cap;
                        n_pick = '0;
                    end
                end
            end
            ST_FILL: begin
                n_j = r_j - CAP_W'(1);
            end
            ST_FLUSH: begin
                n_count = r_count + COUNT_W'(1);
                n_bi    = r_count + COUNT_W'(1);
                n_bj    = r_set_cap;
                n_pick  = '0;
            end
            ST_BT_REQ: begin
            end
            ST_BT_CHK: begin
                if (i_take_bit) begin
                    n_pick[bi_idx] = 1'b1;
                    n_bj           = r_bj - CAP_W'(r_wt[bi_idx]);
                end
                n_bi = r_bi - COUNT_W'(1);
            end
            ST_TOTAL: begin
                if (i_slot_free) begin
                    o_push        = 1'b1;
                    o_res.last_result = (r_pick == '0);
                    o_row_req.clr = 1'b1;
                    n_count       = '0;
                    n_e           = '0;
                end
            end
            ST_EMIT: begin
                if (r_pick[r_e]) begin
                    if (i_slot_free) begin
                        o_push = 1'b1;
                        o_res  = '{result_kind: RES_ITEM,
                                   result_data: DATA_W'(r_e) + DATA_W'(1),
                                   last_result: (pick_rest == '0)};
                        n_pick = pick_rest;
                        n_e    = r_e + IDX_W'(1);
                    end
                end else begin
                    n_e = r_e + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_set_cap <= '0;
            r_s2_vld  <= 1'b0;
            r_pick    <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_set_cap <= n_set_cap;
            r_s2_vld  <= n_s2_vld;
            r_pick    <= n_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_v      <= n_v;
        r_last   <= n_last;
        r_j      <= n_j;
        r_s2_j   <= n_s2_j;
        r_s2_fit <= n_s2_fit;
        r_bi     <= n_bi;
        r_bj     <= n_bj;
        r_e      <= n_e;
        if (wt_we) begin
            r_wt[IDX_W'(r_count)] <= i_in_data.item_weight;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule
